[rtl/mtrp_pkg.sv]
package mtrp_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NEED_MORE = 3'd1,
    ST_INVALID   = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_EXCEPTION = 3'd4,
    ST_RANGE     = 3'd5
  } status_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_TRANSACTION = 2'd0;
  localparam logic [1:0] CFG_UNIT        = 2'd1;
  localparam logic [1:0] CFG_CAPACITY    = 2'd2;

  localparam logic [15:0] TRANSACTION_RESET = 16'd0;
  localparam logic [7:0]  UNIT_RESET        = 8'd0;
  localparam logic [6:0]  CAPACITY_RESET    = 7'd125;

  localparam logic [7:0]  FN_READ     = 8'h03;
  localparam logic [7:0]  FN_EXC_BIT  = 8'h80;
  localparam logic [15:0] LEN_MIN     = 16'd2;
  localparam logic [15:0] LEN_MAX     = 16'd254;
  localparam logic [9:0]  MBAP_SIZE   = 10'd7;
  localparam logic [16:0] PDU_HEAD    = 17'd9;
  localparam logic [8:0]  POS_MAX     = 9'd511;

  typedef struct packed {
    logic [15:0] transaction;
    logic [7:0]  unit;
    logic [6:0]  capacity;
  } cfg_t;

  // One queue entry: an optional register word, then an optional status item
  typedef struct packed {
    logic        has_word;
    logic [15:0] word;
    logic        has_status;
    status_t     status;
    logic [15:0] status_word;
  } entry_t;

endpackage

[rtl/mtrp_front.sv]
module mtrp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  mtrp_pkg::cfg_t       cfg,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_buffer,
  output logic                 push,
  output mtrp_pkg::entry_t     push_entry
);

  localparam logic [8:0] POS_TRANS_HI = 9'd0;
  localparam logic [8:0] POS_TRANS_LO = 9'd1;
  localparam logic [8:0] POS_PROTO_HI = 9'd2;
  localparam logic [8:0] POS_PROTO_LO = 9'd3;
  localparam logic [8:0] POS_LEN_HI   = 9'd4;
  localparam logic [8:0] POS_LEN_LO   = 9'd5;
  localparam logic [8:0] POS_UNIT     = 9'd6;
  localparam logic [8:0] POS_FUNC     = 9'd7;
  localparam logic [8:0] POS_COUNT    = 9'd8;
  localparam logic [8:0] POS_WORDS    = 9'd10;

  logic [8:0]  pos;
  logic [15:0] trans, trans_next;
  logic        pnz, pnz_next;
  logic [15:0] len, len_next;
  logic [7:0]  unit, unit_next;
  logic [7:0]  func, func_next;
  logic [7:0]  count, count_next;
  logic [7:0]  high, high_next;

  logic        header_good;
  logic        emit_word;
  logic [9:0]  size;
  logic [16:0] total;
  mtrp_pkg::status_t st;
  logic [15:0] st_word;

  always_comb begin
    trans_next = trans;
    pnz_next   = pnz;
    len_next   = len;
    unit_next  = unit;
    func_next  = func;
    count_next = count;
    high_next  = high;
    emit_word  = 1'b0;
    case (pos)
      POS_TRANS_HI: trans_next = {data_byte, 8'h00};
      POS_TRANS_LO: trans_next = {trans[15:8], data_byte};
      POS_PROTO_HI, POS_PROTO_LO: begin
        if (data_byte != 8'h00) pnz_next = 1'b1;
      end
      POS_LEN_HI:   len_next   = {data_byte, 8'h00};
      POS_LEN_LO:   len_next   = {len[15:8], data_byte};
      POS_UNIT:     unit_next  = data_byte;
      POS_FUNC:     func_next  = data_byte;
      POS_COUNT:    count_next = data_byte;
      default: begin
        if (pos[0]) begin
          high_next = data_byte;
        end else begin
          emit_word = ((pos - POS_WORDS) < {1'b0, count}) && header_good;
        end
      end
    endcase
  end

  // Header fields are settled by the time any word byte arrives
  always_comb begin
    header_good = !pnz && (len >= mtrp_pkg::LEN_MIN) && (len <= mtrp_pkg::LEN_MAX) &&
                  (trans == cfg.transaction) && (unit == cfg.unit) &&
                  (func == mtrp_pkg::FN_READ) && !count[0] &&
                  ({8'h00, count} + 16'd3 == len) && (count[7:1] <= cfg.capacity);
  end

  // Final status from the header as it stands after this byte
  always_comb begin
    size    = {1'b0, pos} + 10'd1;
    total   = 17'd6 + {1'b0, len_next};
    st_word = 16'h0000;
    if (size < mtrp_pkg::MBAP_SIZE) begin
      st = mtrp_pkg::ST_NEED_MORE;
    end else if (pnz_next) begin
      st = mtrp_pkg::ST_INVALID;
    end else if (len_next < mtrp_pkg::LEN_MIN || len_next > mtrp_pkg::LEN_MAX) begin
      st = mtrp_pkg::ST_INVALID;
    end else if ({7'd0, size} < total) begin
      st = mtrp_pkg::ST_NEED_MORE;
    end else if ({7'd0, size} != total || trans_next != cfg.transaction ||
                 unit_next != cfg.unit) begin
      st = mtrp_pkg::ST_MISMATCH;
    end else if (func_next == (mtrp_pkg::FN_READ | mtrp_pkg::FN_EXC_BIT)) begin
      if (total != mtrp_pkg::PDU_HEAD) begin
        st = mtrp_pkg::ST_INVALID;
      end else begin
        st      = mtrp_pkg::ST_EXCEPTION;
        st_word = {8'h00, count_next};
      end
    end else if (func_next != mtrp_pkg::FN_READ || total < mtrp_pkg::PDU_HEAD) begin
      st = mtrp_pkg::ST_INVALID;
    end else if (count_next[0] || ({9'd0, count_next} + mtrp_pkg::PDU_HEAD != total)) begin
      st = mtrp_pkg::ST_INVALID;
    end else if (count_next[7:1] > cfg.capacity) begin
      st = mtrp_pkg::ST_RANGE;
    end else begin
      st      = mtrp_pkg::ST_OK;
      st_word = {9'd0, count_next[7:1]};
    end
  end

  assign push                   = accept && (emit_word || end_of_buffer);
  assign push_entry.has_word    = emit_word;
  assign push_entry.word        = {high, data_byte};
  assign push_entry.has_status  = end_of_buffer;
  assign push_entry.status      = st;
  assign push_entry.status_word = st_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      trans <= '0;
      pnz   <= 1'b0;
      len   <= '0;
      unit  <= '0;
      func  <= '0;
      count <= '0;
      high  <= '0;
    end else if (accept) begin
      if (end_of_buffer) begin
        // re-arm for the next buffer
        pos   <= '0;
        trans <= '0;
        pnz   <= 1'b0;
        len   <= '0;
        unit  <= '0;
        func  <= '0;
        count <= '0;
        high  <= '0;
      end else begin
        if (pos != mtrp_pkg::POS_MAX) pos <= pos + 9'd1;
        trans <= trans_next;
        pnz   <= pnz_next;
        len   <= len_next;
        unit  <= unit_next;
        func  <= func_next;
        count <= count_next;
        high  <= high_next;
      end
    end
  end

endmodule

[rtl/mtrp_queue.sv]
module mtrp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mtrp_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output mtrp_pkg::entry_t  head_entry
);

  logic             v0, v1;
  mtrp_pkg::entry_t q0, q1;

  assign full       = v1;
  assign head_valid = v0;
  assign head_entry = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      case ({pop, push})
        2'b11: begin
          if (v1) begin
            q0 <= q1;
            q1 <= push_entry;
          end else begin
            q0 <= push_entry;
          end
        end
        2'b10: begin
          q0 <= q1;
          v0 <= v1;
          v1 <= 1'b0;
        end
        2'b01: begin
          if (!v0) begin
            q0 <= push_entry;
            v0 <= 1'b1;
          end else begin
            q1 <= push_entry;
            v1 <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/mtrp_back.sv]
module mtrp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  mtrp_pkg::entry_t  head_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [15:0]       out_word,
  output mtrp_pkg::status_t out_status,
  output logic              out_last
);

  logic word_done;
  logic load;
  logic send_word;

  assign load      = !out_valid || out_ready;
  assign send_word = head_entry.has_word && !word_done;
  // hold the entry after its word when a status item still follows
  assign pop       = load && head_valid && !(send_word && head_entry.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      word_done <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        if (send_word) begin
          out_kind   <= 1'b0;
          out_word   <= head_entry.word;
          out_status <= mtrp_pkg::ST_OK;
          out_last   <= 1'b0;
          word_done  <= head_entry.has_status;
        end else begin
          out_kind   <= 1'b1;
          out_word   <= head_entry.status_word;
          out_status <= head_entry.status;
          out_last   <= 1'b1;
          word_done  <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/modbus_tcp_read_response_parser.sv]
// Channel   Dir  Transaction    Contents (lowest bits first)
// s_axis    in   one byte       tdata: data_byte[7:0]; tlast: end_of_buffer
// m_axis    out  one result     tdata: word[15:0], status[18:16]; tuser: kind; tlast: last
// cfg       in   register write cfg_index 0 transaction, 1 unit, 2 capacity
//
// One byte is taken every cycle while s_tready is high; the parse state updates
// in the same cycle. Results pass through a two-entry queue to a registered
// output; a final byte that completes a word yields two results, the word and
// then its status item. Each result is registered in the queue, then at the output.
// s_tready drops only while the queue is full. Reset (rst, synchronous)
// clears parse state and loads the register defaults.
module modbus_tcp_read_response_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // word[15:0], status[18:16], zero[23:19]
  output logic        m_tuser,   // kind
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  mtrp_pkg::cfg_t    cfg;
  logic              accept;
  logic              push;
  mtrp_pkg::entry_t  push_entry;
  logic              full;
  logic              pop;
  logic              head_valid;
  mtrp_pkg::entry_t  head_entry;
  logic [15:0]       out_word;
  mtrp_pkg::status_t out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.transaction <= mtrp_pkg::TRANSACTION_RESET;
      cfg.unit        <= mtrp_pkg::UNIT_RESET;
      cfg.capacity    <= mtrp_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mtrp_pkg::CFG_TRANSACTION: cfg.transaction <= cfg_data;
        mtrp_pkg::CFG_UNIT:        cfg.unit        <= cfg_data[7:0];
        mtrp_pkg::CFG_CAPACITY:    cfg.capacity    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  mtrp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .data_byte     (s_tdata),
    .end_of_buffer (s_tlast),
    .push          (push),
    .push_entry    (push_entry)
  );

  mtrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  mtrp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_word   (out_word),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

  assign m_tdata = {5'd0, out_status, out_word};

  a_last_marks_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == m_tuser))
    else $error("tlast does not match the status kind");

  a_word_status_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (out_status == mtrp_pkg::ST_OK))
    else $error("register word carries a nonzero status");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

[tb/tb_top.sv]
module tb_top;

  typedef struct packed {
    logic              kind;
    logic [15:0]       word;
    mtrp_pkg::status_t status;
    logic              last;
  } reply_t;

  // One directed byte; pin marks a row whose status item is typed in below
  typedef struct packed {
    logic [7:0]        data;
    logic              eob;
    logic              pin;
    mtrp_pkg::status_t status;
    logic [15:0]       word;
  } step_t;

  localparam int ITEM_TARGET      = 1450;
  localparam int IDLE_LIMIT       = 3000;
  localparam int HOLD_CYCLES      = 300;
  localparam int FRAMES_PER_PHASE = 8;

  localparam step_t DIRECTED [28] = '{
    // one byte only: too short for a header
    '{8'hFF, 1'b1, 1'b1, mtrp_pkg::ST_NEED_MORE, 16'd0},
    // protocol field nonzero
    '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0}, '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0}, '{8'h01, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0}, '{8'h02, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{8'h00, 1'b1, 1'b1, mtrp_pkg::ST_INVALID, 16'd0},
    // well-formed reply with one register word, last byte completes the word
    '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0}, '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0}, '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0}, '{8'h05, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{mtrp_pkg::FN_READ, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{8'h02, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0}, '{8'hFF, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{8'hFF, 1'b1, 1'b1, mtrp_pkg::ST_OK, 16'd1},
    // exception reply carrying code 2
    '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0}, '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0}, '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0}, '{8'h03, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{8'h00, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{mtrp_pkg::FN_READ | mtrp_pkg::FN_EXC_BIT, 1'b0, 1'b0, mtrp_pkg::ST_OK, 16'd0},
    '{8'h02, 1'b1, 1'b1, mtrp_pkg::ST_EXCEPTION, 16'd2}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // data_byte[7:0]
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // word[15:0], status[18:16], zero[23:19]
  logic        m_tuser;           // kind
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = mtrp_pkg::CFG_TRANSACTION;
  logic [15:0] cfg_data = 16'h0000;

  // typed-in status for the byte currently offered, travels with s_tdata
  logic              pin_en = 1'b0;
  mtrp_pkg::status_t pin_status = mtrp_pkg::ST_OK;
  logic [15:0]       pin_word = 16'h0000;

  logic        tx_steady = 1'b0;
  logic        rx_steady = 1'b0;
  logic        choke_req = 1'b0;

  // parser mirror
  logic [8:0]  pos_q = '0;
  logic [15:0] rx_trans = '0;
  logic        proto_bad = 1'b0;
  logic [15:0] rx_len = '0;
  logic [7:0]  rx_unit = '0;
  logic [7:0]  rx_fn = '0;
  logic [7:0]  rx_bc = '0;
  logic [7:0]  hi_byte = '0;
  logic [15:0] want_trans = mtrp_pkg::TRANSACTION_RESET;
  logic [7:0]  want_unit = mtrp_pkg::UNIT_RESET;
  logic [6:0]  want_cap = mtrp_pkg::CAPACITY_RESET;

  reply_t      reply_q [$];
  reply_t      rx_got;
  reply_t      rx_want;
  reply_t      pinned;
  logic [7:0]  frame [$];

  int mismatches = 0;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int buffers_seen = 0;
  int words_seen = 0;
  int settings = 0;
  int status_seen [6] = '{default: 0};

  always #1 clk = ~clk;

  modbus_tcp_read_response_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic words_allowed();
    int total;
    total = 6 + int'(rx_len);
    if (proto_bad || rx_len < mtrp_pkg::LEN_MIN || rx_len > mtrp_pkg::LEN_MAX) return 1'b0;
    if (rx_trans != want_trans || rx_unit != want_unit) return 1'b0;
    if (rx_fn != mtrp_pkg::FN_READ || rx_bc[0]) return 1'b0;
    if (int'(rx_bc) + int'(mtrp_pkg::PDU_HEAD) != total) return 1'b0;
    return (rx_bc / 2) <= want_cap;
  endfunction

  function automatic mtrp_pkg::status_t closing_status(input int size,
                                                       output logic [15:0] w);
    int total;
    int count;
    total = 6 + int'(rx_len);   // MBAP bytes ahead of the unit plus declared length
    count = int'(rx_bc) / 2;
    w = 16'h0000;
    if (size < int'(mtrp_pkg::MBAP_SIZE)) return mtrp_pkg::ST_NEED_MORE;
    if (proto_bad) return mtrp_pkg::ST_INVALID;
    if (rx_len < mtrp_pkg::LEN_MIN || rx_len > mtrp_pkg::LEN_MAX) return mtrp_pkg::ST_INVALID;
    if (size < total) return mtrp_pkg::ST_NEED_MORE;
    if (size != total || rx_trans != want_trans || rx_unit != want_unit)
      return mtrp_pkg::ST_MISMATCH;
    if (rx_fn == (mtrp_pkg::FN_READ | mtrp_pkg::FN_EXC_BIT)) begin
      if (total != int'(mtrp_pkg::PDU_HEAD)) return mtrp_pkg::ST_INVALID;
      w = {8'h00, rx_bc};
      return mtrp_pkg::ST_EXCEPTION;
    end
    if (rx_fn != mtrp_pkg::FN_READ || total < int'(mtrp_pkg::PDU_HEAD))
      return mtrp_pkg::ST_INVALID;
    if (rx_bc[0] || int'(rx_bc) + int'(mtrp_pkg::PDU_HEAD) != total)
      return mtrp_pkg::ST_INVALID;
    if (count > int'(want_cap)) return mtrp_pkg::ST_RANGE;
    w = 16'(count);
    return mtrp_pkg::ST_OK;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic eob);
    logic [8:0]        p;
    logic [15:0]       w;
    mtrp_pkg::status_t st;
    p = pos_q;
    case (p)
      9'd0: rx_trans = {b, 8'h00};
      9'd1: rx_trans[7:0] = b;
      9'd2, 9'd3: if (b != 8'h00) proto_bad = 1'b1;
      9'd4: rx_len = {b, 8'h00};
      9'd5: rx_len[7:0] = b;
      9'd6: rx_unit = b;
      9'd7: rx_fn = b;
      9'd8: rx_bc = b;
      default: begin
        if (p[0]) begin
          hi_byte = b;
        end else if (int'(p) - 10 < int'(rx_bc) && words_allowed()) begin
          reply_q.push_back('{1'b0, {hi_byte, b}, mtrp_pkg::ST_OK, 1'b0});
        end
      end
    endcase
    if (eob) begin
      st = closing_status(int'(p) + 1, w);
      reply_q.push_back('{1'b1, w, st, 1'b1});
      // re-arm for the next buffer
      pos_q = '0;
      rx_trans = '0;
      proto_bad = 1'b0;
      rx_len = '0;
      rx_unit = '0;
      rx_fn = '0;
      rx_bc = '0;
      hi_byte = '0;
    end else if (p != mtrp_pkg::POS_MAX) begin
      pos_q = p + 9'd1;
    end
  endfunction

  function automatic string show(input reply_t r);
    return $sformatf("kind %0d word %04h status %0d last %0d", r.kind, r.word, r.status, r.last);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic int pick_gap(input logic steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Lay out a well-formed read reply with n register words of random content
  function automatic void lay_read(input int n);
    logic [15:0] len;
    logic [7:0]  head [9];
    len = 16'(3 + 2 * n);
    head = '{want_trans[15:8], want_trans[7:0], 8'h00, 8'h00, len[15:8], len[7:0],
             want_unit, mtrp_pkg::FN_READ, 8'(2 * n)};
    frame.delete();
    foreach (head[i]) frame.push_back(head[i]);
    repeat (2 * n) frame.push_back(8'($urandom));
  endfunction

  function automatic void lay_random_frame();
    int          pick;
    int          n;
    int          keep;
    int          at;
    logic [15:0] v;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 2) n = $urandom_range(60, 125);
    else if (want_cap <= 10 && $urandom_range(0, 3) == 0) n = int'(want_cap) + $urandom_range(0, 1);
    else n = $urandom_range(0, 8);
    if (pick < 10) begin
      frame.delete();
      repeat ($urandom_range(1, 20)) frame.push_back(8'($urandom));
    end else if (pick < 22) begin
      lay_read(0);
      frame[7] = mtrp_pkg::FN_READ | mtrp_pkg::FN_EXC_BIT;
      frame[8] = 8'($urandom);
      // exception reply one byte too long
      if ($urandom_range(0, 3) == 0) begin
        frame[5] = 8'd4;
        frame.push_back(8'($urandom));
      end
    end else begin
      lay_read(n);
      if (pick >= 60) begin
        case ($urandom_range(0, 8))
          0: frame[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
          1: frame[6] ^= 8'(1 << $urandom_range(0, 7));
          2: frame[$urandom_range(2, 3)] = 8'($urandom_range(1, 255));
          3: begin
            case ($urandom_range(0, 3))
              0: v = 16'($urandom_range(0, 1));
              1: v = 16'($urandom_range(255, 65535));
              2: v = {frame[4], frame[5]} + (($urandom_range(0, 1) != 0) ? 16'd2 : 16'hFFFF);
              default: v = 16'($urandom);
            endcase
            frame[4] = v[15:8];
            frame[5] = v[7:0];
          end
          4: frame[7] = 8'($urandom);
          5: frame[8] ^= 8'(1 << $urandom_range(0, 7));
          6: begin
            keep = $urandom_range(1, frame.size() - 1);
            while (frame.size() > keep) void'(frame.pop_back());
          end
          7: repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
          default: begin
            at = $urandom_range(0, frame.size() - 1);
            frame[at] ^= 8'(1 << $urandom_range(0, 7));
          end
        endcase
      end
    end
  endfunction

  // Idle first, then offer the byte and hold it until it is taken
  task automatic send_byte(input logic [7:0] b, input logic eob, input logic pin,
                           input mtrp_pkg::status_t st, input logic [15:0] w);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eob;
    pin_en <= pin;
    pin_status <= st;
    pin_word <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i])
      send_byte(frame[i], i == frame.size() - 1, 1'b0, mtrp_pkg::ST_OK, 16'd0);
  endtask

  // Wait until every reply is in and the parser has settled
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      mtrp_pkg::CFG_TRANSACTION: want_trans = val;
      mtrp_pkg::CFG_UNIT: want_unit = val[7:0];
      default: want_cap = val[6:0];
    endcase
  endtask

  task automatic program_regs(input logic [15:0] t, input logic [7:0] u, input logic [6:0] c);
    // upper bits are junk; the registers keep only their own width
    write_reg(mtrp_pkg::CFG_TRANSACTION, t);
    write_reg(mtrp_pkg::CFG_UNIT, {8'($urandom), u});
    write_reg(mtrp_pkg::CFG_CAPACITY, {9'($urandom), c});
    cfg_we <= 1'b0;
    settings++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        rx_got = '{m_tuser, m_tdata[15:0], mtrp_pkg::status_t'(m_tdata[18:16]), m_tlast};
        if (rx_got.kind !== 1'b1) words_seen++;
        else if (m_tdata[18:16] <= 3'd5) status_seen[m_tdata[18:16]]++;
        if (reply_q.size() == 0) begin
          note_mismatch({"unexpected result: ", show(rx_got)});
        end else begin
          rx_want = reply_q.pop_front();
          if (rx_got.kind !== rx_want.kind || rx_got.word !== rx_want.word ||
              rx_got.status !== rx_want.status || rx_got.last !== rx_want.last)
            note_mismatch({"got ", show(rx_got), ", expected ", show(rx_want)});
        end
      end
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, s_tlast);
        if (s_tlast) buffers_seen++;
        if (pin_en) begin
          pinned = reply_q.pop_back();
          pinned.status = pin_status;
          pinned.word = pin_word;
          reply_q.push_back(pinned);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d replies pending",
               idle_cycles, reply_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int   run;
    int   stall;
    logic choked;
    choked = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      run = $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (choke_req && !choked) begin
        // hold off long enough for the parser to back up into its input
        choked = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap(rx_steady);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].data, DIRECTED[i].eob, DIRECTED[i].pin,
                DIRECTED[i].status, DIRECTED[i].word);
    drain();
    phase = 0;
    while (bytes_sent < ITEM_TARGET) begin
      case (phase)
        0: program_regs(16'hFFFF, 8'hFF, 7'd0);
        1: program_regs(16'h0000, 8'h00, 7'd125);
        default: begin
          program_regs(16'($urandom), 8'($urandom),
                       ($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 10)) : 7'($urandom));
        end
      endcase
      rx_steady <= ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        // full-size reply sent back to back while the output is held off
        tx_steady = 1'b1;
        choke_req <= 1'b1;
        lay_read(125);
        send_frame();
        // overlong buffer: position saturates, a few words precede the status
        tx_steady = 1'b0;
        lay_read(3);
        while (frame.size() < 512 + $urandom_range(0, 8)) frame.push_back(8'($urandom));
        send_frame();
      end
      repeat (FRAMES_PER_PHASE) begin
        tx_steady = ($urandom_range(0, 4) == 0);
        lay_random_frame();
        send_frame();
      end
      drain();
      phase++;
    end
    $display("Parsed %0d bytes in %0d buffers under %0d register settings besides reset,",
             bytes_sent, buffers_seen, settings);
    $display("%0d register words; ok/need-more/invalid/mismatch/exception/range %0d/%0d/%0d/%0d/%0d/%0d",
             words_seen, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mtrp_pkg.sv
rtl/mtrp_front.sv
rtl/mtrp_queue.sv
rtl/mtrp_back.sv
rtl/modbus_tcp_read_response_parser.sv
tb/tb_top.sv
